// ----- src/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; no other dependencies.
package spq_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int PRIO_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOKEY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        op_t                      op;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } ctrl_t;

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted chain: holds a key/priority entry and shifts
// toward its neighbors on insert and removal. Depends on spq_pkg.
module spq_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  spq_pkg::ctrl_t  ctrl,
    input  spq_pkg::entry_t left,
    input  spq_pkg::entry_t right,
    input  logic            ge_in,
    input  logic            seen_in,
    output logic            ge_out,
    output logic            seen_out,
    output logic            hit,
    output spq_pkg::entry_t entry
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [spq_pkg::KEY_W-1:0]       key_reg;
    logic [spq_pkg::KEY_W-1:0]       key_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;

    assign ge_out = valid_reg && (prio_reg >= ctrl.prio);

    // A pop removes the head, so every cell counts as past the match.
    assign seen_out = (ctrl.op == spq_pkg::OP_POP) ? 1'b1
                    : (seen_in || (valid_reg && (key_reg == ctrl.key)));
    assign hit = seen_out && !seen_in;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        prio_next  = prio_reg;
        case (ctrl.op) inside
            spq_pkg::OP_INSERT:
            begin
                if (!ge_out)
                begin
                    if (ge_in)
                    begin
                        valid_next = 1'b1;
                        key_next   = ctrl.key;
                        prio_next  = ctrl.prio;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        key_next   = left.key;
                        prio_next  = left.prio;
                    end
                end
            end
            spq_pkg::OP_REMOVE, spq_pkg::OP_POP:
            begin
                if (seen_out)
                begin
                    valid_next = right.valid;
                    key_next   = right.key;
                    prio_next  = right.prio;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

    assign entry = '{valid: valid_reg, key: key_reg, prio: prio_reg};

endmodule

// ----- src/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: command handshake, sequencer and
// a chain of spq_cell slots. Depends on spq_pkg and spq_cell.
//
// Usage: each input word on s_* carries one command (insert, pop head, or
// change the priority of a key). Each command yields exactly one output word
// on m_* with a status code, the popped or changed key, the popped or old
// priority, and the occupancy after the command.
// Sequencing: for insert, pop, unknown codes and refused commands the
// sequencer passes through S_EXEC once and the output word is registered
// as it returns to S_IDLE; a change that finds its key needs one removal
// pass in S_EXEC and one insertion pass in S_REINS before its word is
// registered. Every slot moves in parallel with its neighbors, so no pass
// depends on DEPTH. One command is processed at a time: the next command
// is taken only once the sequencer is back in S_IDLE.
// The output word sits in a register; the next command is accepted while it
// waits only if it is taken in the same cycle, so a stalled receiver holds
// back the input side after at most one word.
// Reset empties the queue at once; slot contents are left as they were and
// are never read until rewritten.
module sorted_priority_queue_top #(
    parameter int DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], key[33:2], priority_req[65:34], zero fill
    input  logic [spq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], out_key[33:2], out_priority[65:34], occupancy[70:66], zero
    output logic [spq_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_REINS = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic [spq_pkg::CMD_W-1:0]            cmd_reg;
    logic [spq_pkg::KEY_W-1:0]            key_reg;
    logic signed [spq_pkg::PRIO_W-1:0]    prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0]    old_prio_reg, old_prio_next;
    logic [CNT_W-1:0]                     count_reg, count_next;

    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [spq_pkg::STAT_W-1:0]           status_reg, status_next;
    logic [spq_pkg::KEY_W-1:0]            out_key_reg, out_key_next;
    logic signed [spq_pkg::PRIO_W-1:0]    out_prio_reg, out_prio_next;
    logic [spq_pkg::OCC_W-1:0]            occ_reg, occ_next;

    spq_pkg::ctrl_t                       ctrl;
    spq_pkg::entry_t                      cell_q [DEPTH];
    logic [DEPTH:0]                       ge;
    logic [DEPTH:0]                       seen;
    logic [DEPTH-1:0]                     hit;
    logic [DEPTH-1:0]                     valid_vec;
    logic [spq_pkg::KEY_W-1:0]            hit_key;
    logic signed [spq_pkg::PRIO_W-1:0]    hit_prio;
    logic                                 accept;
    logic                                 found;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // A new entry goes ahead of slot 0 unless slot 0 holds a valid entry of equal or higher priority.
    assign ge[0]   = 1'b1;
    assign seen[0] = 1'b0;
    assign found   = seen[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_e, right_e;
        if (i == 0)
        begin : g_first
            assign left_e = '0;
        end
        else
        begin : g_mid_l
            assign left_e = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_mid_r
            assign right_e = cell_q[i+1];
        end

        spq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .left     (left_e),
            .right    (right_e),
            .ge_in    (ge[i]),
            .seen_in  (seen[i]),
            .ge_out   (ge[i+1]),
            .seen_out (seen[i+1]),
            .hit      (hit[i]),
            .entry    (cell_q[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    // At most one cell flags the first match, so an AND-OR select suffices.
    always_comb
    begin
        hit_key  = '0;
        hit_prio = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_key  = hit_key  | ({spq_pkg::KEY_W{hit[i]}}  & cell_q[i].key);
            hit_prio = hit_prio | ({spq_pkg::PRIO_W{hit[i]}} & cell_q[i].prio);
        end
    end

    // The chain operation depends only on the sequencer state, the command and the entry count, never on the
    // match result that the chain itself produces.
    always_comb
    begin
        ctrl = '{op: spq_pkg::OP_HOLD, key: key_reg, prio: prio_reg};
        unique case (state_reg)
            S_EXEC:
            begin
                case (cmd_reg)
                    spq_pkg::CMD_INSERT:
                    begin
                        if (count_reg != CNT_FULL)
                        begin
                            ctrl.op = spq_pkg::OP_INSERT;
                        end
                    end
                    spq_pkg::CMD_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            ctrl.op = spq_pkg::OP_POP;
                        end
                    end
                    spq_pkg::CMD_CHANGE:
                    begin
                        // With no match nothing shifts, so removal is safe to issue.
                        if (count_reg != '0)
                        begin
                            ctrl.op = spq_pkg::OP_REMOVE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_REINS:
            begin
                ctrl.op = spq_pkg::OP_INSERT;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        old_prio_next = old_prio_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        out_key_next  = out_key_reg;
        out_prio_next = out_prio_reg;
        occ_next      = occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                m_tvalid_next = 1'b1;
                status_next   = spq_pkg::ST_OK;
                out_key_next  = '0;
                out_prio_next = '0;
                state_next    = S_IDLE;
                case (cmd_reg)
                    spq_pkg::CMD_INSERT:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            status_next = spq_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    spq_pkg::CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_key_next  = hit_key;
                            out_prio_next = hit_prio;
                            count_next    = count_reg - CNT_ONE;
                        end
                    end
                    spq_pkg::CMD_CHANGE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            if (found)
                            begin
                                m_tvalid_next = 1'b0;
                                old_prio_next = hit_prio;
                                count_next    = count_reg - CNT_ONE;
                                state_next    = S_REINS;
                            end
                            else
                            begin
                                status_next = spq_pkg::ST_NOKEY;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                occ_next = spq_pkg::OCC_W'(count_next);
            end
            S_REINS:
            begin
                count_next    = count_reg + CNT_ONE;
                m_tvalid_next = 1'b1;
                status_next   = spq_pkg::ST_OK;
                out_key_next  = key_reg;
                out_prio_next = old_prio_reg;
                occ_next      = spq_pkg::OCC_W'(count_next);
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_tdata[1:0];
            key_reg  <= s_tdata[33:2];
            prio_reg <= s_tdata[65:34];
        end
        old_prio_reg <= old_prio_next;
        status_reg   <= status_next;
        out_key_reg  <= out_key_next;
        out_prio_reg <= out_prio_next;
        occ_reg      <= occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, occ_reg, out_prio_reg, out_key_reg, status_reg};

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds queue depth");

    a_valid_match : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("slot valid bits disagree with entry count");

    a_out_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !m_tvalid_reg)
        else $error("output register busy while a command is in progress");

    a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted command did not start execution");

endmodule
